[hdl/espc_pkg.sv]
// ----------------------------------------------------------------------------
// espc_pkg
// Types and constants shared by the edge step position controller.
// ----------------------------------------------------------------------------
package espc_pkg;

   localparam int unsigned SETTLE_CHECKS = 5;
   localparam int unsigned SETTLE_MAX    = 7;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_STEPS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_SPEED   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_SPEED  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_SCALE  = 3'd3;

   // operation codes
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [8:0] BRAKE_SCALE_RESET = 9'd128;

   typedef struct packed {
      logic [14:0]        target_steps;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic [8:0]         brake_scale;
   } esp_cfg_type;

   // classified item passed from front to back
   typedef struct packed {
      logic               done;
      logic               dir_pos;
      logic               dir_neg;
      logic               brake;
      logic signed [15:0] count;
   } esp_cmd_type;

   // Scale by the Q8 brake factor (truncate toward zero), apply direction,
   // saturate to 16 bits.
   function automatic logic signed [15:0] drive_calc(
      input logic signed [15:0] speed,
      input logic [8:0]         scale,
      input logic               dir_pos,
      input logic               dir_neg,
      input logic               brake
   );
      logic signed [25:0] sp_wide;
      logic signed [25:0] sc_wide;
      logic signed [25:0] prod;
      logic signed [25:0] adj;
      logic signed [17:0] mag;
      logic signed [17:0] val;
      logic signed [15:0] res;
      sp_wide = {{10{speed[15]}}, speed};
      sc_wide = {17'd0, scale};
      prod    = sp_wide * sc_wide;
      adj     = prod[25] ? (prod + 26'sd255) : prod;
      mag     = brake ? adj[25:8] : {{2{speed[15]}}, speed};
      if (dir_neg) begin
         val = -mag;
      end else if (dir_pos) begin
         val = mag;
      end else begin
         val = 18'sd0;
      end
      if (val > 18'sd32767) begin
         res = 16'sh7fff;
      end else if (val < -18'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = val[15:0];
      end
      return res;
   endfunction

endpackage

[hdl/esp_req_if.sv]
// ----------------------------------------------------------------------------
// esp_req_if
// Request channel: start or sensor sample items.
// ----------------------------------------------------------------------------
interface esp_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic sensor_level;
   logic period_elapsed;

   modport source (output valid, output operation, output sensor_level,
                   output period_elapsed, input ready);
   modport sink   (input valid, input operation, input sensor_level,
                   input period_elapsed, output ready);
endinterface

[hdl/esp_rsp_if.sv]
// ----------------------------------------------------------------------------
// esp_rsp_if
// Response channel: drive commands and move status.
// ----------------------------------------------------------------------------
interface esp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_drive;
   logic signed [15:0] right_drive;
   logic signed [15:0] steps_travelled;
   logic               move_done;

   modport source (output valid, output left_drive, output right_drive,
                   output steps_travelled, output move_done, input ready);
   modport sink   (input valid, input left_drive, input right_drive,
                   input steps_travelled, input move_done, output ready);
endinterface

[hdl/espc_front.sv]
// ----------------------------------------------------------------------------
// espc_front
// Accepts items, tracks the move state and classifies each item.
// ----------------------------------------------------------------------------
module espc_front (
   input  logic                  clock,
   input  logic                  reset,
   esp_req_if.sink               req,
   input  logic [14:0]           target_steps,
   output logic                  push_valid,
   output espc_pkg::esp_cmd_type push_cmd,
   input  logic                  push_ready
);
   import espc_pkg::*;

   logic               awaited_ff, awaited_in;
   logic signed [15:0] count_ff, count_in;
   logic               rev_ff, rev_in;
   logic [2:0]         settle_ff, settle_in;
   logic               fin_ff, fin_in;

   logic               accept;
   logic               hit;
   logic signed [15:0] count_step;
   logic signed [17:0] diff;
   logic [16:0]        distance;
   logic [2:0]         settle_inc;
   logic               at_target;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   always_comb begin
      hit = (req.sensor_level == awaited_ff);
      if (!hit) begin
         count_step = count_ff;
      end else if (rev_ff) begin
         count_step = (count_ff == 16'sh8000) ? count_ff : count_ff - 16'sd1;
      end else begin
         count_step = (count_ff == 16'sh7fff) ? count_ff : count_ff + 16'sd1;
      end
      diff       = $signed({3'b000, target_steps}) - {{2{count_step[15]}}, count_step};
      distance   = diff[17] ? 17'(-diff) : diff[16:0];
      at_target  = (count_step == $signed({1'b0, target_steps}));
      settle_inc = (settle_ff < 3'(SETTLE_MAX)) ? settle_ff + 3'd1 : settle_ff;

      awaited_in = awaited_ff;
      count_in   = count_ff;
      rev_in     = rev_ff;
      settle_in  = settle_ff;
      fin_in     = fin_ff;
      push_cmd   = '0;

      if (req.operation == OP_START) begin
         count_in         = '0;
         awaited_in       = ~req.sensor_level;
         rev_in           = 1'b0;
         settle_in        = '0;
         fin_in           = 1'b0;
         push_cmd.dir_pos = 1'b1;
      end else if (fin_ff) begin
         push_cmd.done  = 1'b1;
         push_cmd.count = count_ff;
      end else begin
         awaited_in = hit ? ~awaited_ff : awaited_ff;
         count_in   = count_step;
         rev_in     = diff[17];
         if (req.period_elapsed) begin
            if (at_target) begin
               settle_in = settle_inc;
               fin_in    = (settle_inc >= 3'(SETTLE_CHECKS));
            end else begin
               settle_in = '0;
            end
         end
         push_cmd.done    = fin_in;
         push_cmd.dir_pos = !diff[17] && (diff != 18'sd0);
         push_cmd.dir_neg = diff[17];
         push_cmd.brake   = (distance <= {3'b000, target_steps[14:1]});
         push_cmd.count   = count_step;
      end
   end

   assign push_valid = req.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         awaited_ff <= 1'b0;
         count_ff   <= '0;
         rev_ff     <= 1'b0;
         settle_ff  <= '0;
         fin_ff     <= 1'b1;
      end else if (accept) begin
         awaited_ff <= awaited_in;
         count_ff   <= count_in;
         rev_ff     <= rev_in;
         settle_ff  <= settle_in;
         fin_ff     <= fin_in;
      end
   end

endmodule

[hdl/espc_queue.sv]
// ----------------------------------------------------------------------------
// espc_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module espc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  espc_pkg::esp_cmd_type push_cmd,
   output logic                  push_ready,
   output logic                  pop_valid,
   output espc_pkg::esp_cmd_type pop_cmd,
   input  logic                  pop_ready
);
   import espc_pkg::*;

   esp_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/espc_back.sv]
// ----------------------------------------------------------------------------
// espc_back
// Computes the drive commands and holds them in the output register.
// ----------------------------------------------------------------------------
module espc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  espc_pkg::esp_cmd_type pop_cmd,
   output logic                  pop_ready,
   input  espc_pkg::esp_cfg_type cfg,
   esp_rsp_if.source             rsp
);
   import espc_pkg::*;

   logic               valid_ff, valid_in;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] right_ff, right_in;
   logic signed [15:0] count_ff;
   logic               done_ff;
   logic               load;

   assign pop_ready = !valid_ff || rsp.ready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      valid_in = load ? 1'b1 : (valid_ff && !rsp.ready);
      if (pop_cmd.done) begin
         left_in  = '0;
         right_in = '0;
      end else begin
         left_in  = drive_calc(cfg.left_speed, cfg.brake_scale, pop_cmd.dir_pos,
                               pop_cmd.dir_neg, pop_cmd.brake);
         right_in = drive_calc(cfg.right_speed, cfg.brake_scale, pop_cmd.dir_pos,
                               pop_cmd.dir_neg, pop_cmd.brake);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         count_ff <= pop_cmd.count;
         done_ff  <= pop_cmd.done;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.left_drive      = left_ff;
   assign rsp.right_drive     = right_ff;
   assign rsp.steps_travelled = count_ff;
   assign rsp.move_done       = done_ff;

endmodule

[hdl/edge_step_position_controller_unit.sv]
// ----------------------------------------------------------------------------
// edge_step_position_controller_unit
// Edge-counting bang-bang position controller with a brake zone near target.
// ----------------------------------------------------------------------------
//
//   channel | direction | carries
//   --------+-----------+-------------------------------------------------
//   req_bus | in        | operation, sensor_level, period_elapsed
//   rsp_bus | out       | left_drive, right_drive, steps_travelled, move_done
//   csr_*   | in        | register writes: target, speeds, brake scale
//
// One item per clock sustained while rsp_bus is ready; each item gives
// exactly one result, valid on rsp_bus after the queue entry, written at the
// accept edge, and then the drive multiply into the output register.
// The move state updates in the front in the accept cycle, so consecutive
// samples see each other's effect with no bubble.
// A two-entry queue parts front and back: a stalled rsp_bus fills the queue
// before req_bus ready drops. Reset is synchronous; after it the controller
// is idle (finished) and brake_scale is 128.
// ----------------------------------------------------------------------------
module edge_step_position_controller_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   esp_req_if.sink                              req_bus,
   esp_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write,
   input  logic [espc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [espc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import espc_pkg::*;

   esp_cfg_type cfg_ff;
   esp_cmd_type push_cmd;
   esp_cmd_type pop_cmd;
   logic        push_valid, push_ready;
   logic        pop_valid, pop_ready;

   // Configuration registers; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_steps <= '0;
         cfg_ff.left_speed   <= '0;
         cfg_ff.right_speed  <= '0;
         cfg_ff.brake_scale  <= BRAKE_SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TARGET_STEPS: cfg_ff.target_steps <= csr_data[14:0];
            CSR_LEFT_SPEED:   cfg_ff.left_speed   <= csr_data;
            CSR_RIGHT_SPEED:  cfg_ff.right_speed  <= csr_data;
            CSR_BRAKE_SCALE:  cfg_ff.brake_scale  <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   // Front: accept, advance the edge count and classify direction and brake.
   espc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .target_steps (cfg_ff.target_steps),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd),
      .push_ready   (push_ready)
   );

   // Queue: hold classified items while the result side stalls.
   espc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   // Back: scale the speeds and register the result.
   espc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .cfg       (cfg_ff),
      .rsp       (rsp_bus)
   );

endmodule

[tb/edge_step_position_controller_unit_tb.sv]
// ----------------------------------------------------------------------------
// edge_step_position_controller_unit_tb
// Self-checking bench for the edge step position controller. A queue-fed
// driver offers start and sensor sample items in bursts. A monitor predicts
// every drive command and compares it with the result channel. Register
// settings change between phases while the controller is idle.
// ----------------------------------------------------------------------------
module edge_step_position_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import espc_pkg::*;

   // Longest stretch with no handshake on either side before the run is
   // declared hung. The deliberate result hold-off is far shorter.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_PAUSE   = 6;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 125;
   localparam int MAX_REPORTS    = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNMAPPED = CSR_BRAKE_SCALE + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX     = {CSR_INDEX_W{1'b1}};

   typedef struct packed {
      logic operation;
      logic sensor_level;
      logic period_elapsed;
   } motion_item_type;

   typedef struct packed {
      logic signed [15:0] left_drive;
      logic signed [15:0] right_drive;
      logic signed [15:0] steps;
      logic               done;
   } drive_cmd_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN,
      RX_SPARSE
   } rx_mode_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   esp_req_if req_bus ();
   esp_rsp_if rsp_bus ();

   edge_step_position_controller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Controller copy: register settings and move state.
   esp_cfg_type        cfg;
   logic               awaited_lvl;
   logic signed [15:0] edge_count;
   logic               reverse_dir;
   logic [2:0]         settle_cnt;
   logic               move_finished;

   motion_item_type pending_items[$];
   drive_cmd_type   predicted_cmds[$];

   int          failures;
   int          idle_cycles;
   int          items_queued;
   bit          req_taken;
   int          burst_left;
   int          gap_left;
   int          sender_gap_max;
   rx_mode_type rsp_mode;
   bit          rsp_hold_request;
   int          hold_left;
   int          ready_phase;

   // Clock: 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Scale by the brake factor (truncate toward zero), apply direction,
   // clamp to 16 bits.
   function automatic logic signed [15:0] scaled_drive(input logic signed [15:0] speed,
                                                       input int dir, input bit braking);
      int mag;
      int val;
      mag = braking ? (int'(speed) * int'(cfg.brake_scale)) / 256 : int'(speed);
      val = mag * dir;
      if (val > 32767) return 16'sh7fff;
      if (val < -32768) return 16'sh8000;
      return val[15:0];
   endfunction

   // Advance the move state by one item and return the drive command it gives.
   function automatic drive_cmd_type controller_step(input motion_item_type it);
      drive_cmd_type cmd;
      int            tgt;
      int            diff;
      int            distance;
      int            dir;
      bit            braking;
      tgt = int'(cfg.target_steps);
      if (it.operation == OP_START) begin
         // Arm the move; the tick bit is ignored here.
         edge_count    = '0;
         awaited_lvl   = ~it.sensor_level;
         reverse_dir   = 1'b0;
         settle_cnt    = '0;
         move_finished = 1'b0;
         cmd.left_drive  = cfg.left_speed;
         cmd.right_drive = cfg.right_speed;
         cmd.steps       = '0;
         cmd.done        = 1'b0;
         return cmd;
      end
      if (move_finished) begin
         // Idle or done: hold everything, report zero drive.
         cmd.left_drive  = '0;
         cmd.right_drive = '0;
         cmd.steps       = edge_count;
         cmd.done        = 1'b1;
         return cmd;
      end
      if (it.sensor_level == awaited_lvl) begin
         awaited_lvl = ~awaited_lvl;
         if (reverse_dir) begin
            if (edge_count != 16'sh8000) edge_count = edge_count - 16'sd1;
         end else begin
            if (edge_count != 16'sh7fff) edge_count = edge_count + 16'sd1;
         end
      end
      diff        = tgt - int'(edge_count);
      dir         = (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
      distance    = (diff < 0) ? -diff : diff;
      braking     = !(distance > tgt / 2);
      reverse_dir = (dir < 0);
      if (it.period_elapsed) begin
         if (int'(edge_count) == tgt) begin
            if (settle_cnt < SETTLE_MAX) settle_cnt = settle_cnt + 3'd1;
            if (settle_cnt >= SETTLE_CHECKS) move_finished = 1'b1;
         end else begin
            settle_cnt = '0;
         end
      end
      cmd.steps = edge_count;
      if (move_finished) begin
         cmd.left_drive  = '0;
         cmd.right_drive = '0;
         cmd.done        = 1'b1;
      end else begin
         cmd.left_drive  = scaled_drive(cfg.left_speed, dir, braking);
         cmd.right_drive = scaled_drive(cfg.right_speed, dir, braking);
         cmd.done        = 1'b0;
      end
      return cmd;
   endfunction

   function automatic void note_failure(input string what, input drive_cmd_type want,
                                        input drive_cmd_type got);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0t %s: expected L=%0d R=%0d N=%0d D=%0b, got L=%0d R=%0d N=%0d D=%0b",
                  $realtime, what, want.left_drive, want.right_drive, want.steps, want.done,
                  got.left_drive, got.right_drive, got.steps, got.done);
   endfunction

   // Sender: present the head of the queue, hold it until taken, idle in gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_bus.valid          <= 1'b1;
            req_bus.operation      <= pending_items[0].operation;
            req_bus.sensor_level   <= pending_items[0].sensor_level;
            req_bus.period_elapsed <= pending_items[0].period_elapsed;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: a long hold-off on request, otherwise the phase's stall pattern.
   always @(negedge clock) begin
      ready_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_request) begin
         rsp_hold_request = 1'b0;
         hold_left        = HOLD_CYCLES;
         rsp_bus.ready   <= 1'b0;
      end else begin
         case (rsp_mode)
            RX_ALWAYS:  rsp_bus.ready <= 1'b1;
            RX_RANDOM:  rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: rsp_bus.ready <= (ready_phase % 7) < 4;
            default:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor: predict on every accepted item, check every accepted result.
   always @(posedge clock) begin
      drive_cmd_type got;
      drive_cmd_type want;
      bit            moved;
      moved     = 1'b0;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            moved     = 1'b1;
            predicted_cmds.push_back(controller_step(pending_items.pop_front()));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved           = 1'b1;
            got.left_drive  = rsp_bus.left_drive;
            got.right_drive = rsp_bus.right_drive;
            got.steps       = rsp_bus.steps_travelled;
            got.done        = rsp_bus.move_done;
            if (predicted_cmds.size() == 0) begin
               note_failure("unexpected result", '0, got);
            end else begin
               want = predicted_cmds.pop_front();
               if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                   got.steps !== want.steps || got.done !== want.done)
                  note_failure("mismatch", want, got);
            end
         end
      end
      // Watchdog: give up when nothing moves for too long.
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_item(input logic op, input logic lvl, input logic tick);
      motion_item_type it;
      it.operation      = op;
      it.sensor_level   = lvl;
      it.period_elapsed = tick;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Write one register at a falling edge; update the local copy to match.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_TARGET_STEPS: cfg.target_steps = data[14:0];
         CSR_LEFT_SPEED:   cfg.left_speed   = data;
         CSR_RIGHT_SPEED:  cfg.right_speed  = data;
         CSR_BRAKE_SCALE:  cfg.brake_scale  = data[8:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int tgt, input logic [15:0] left, input logic [15:0] right,
                            input logic [8:0] scale);
      logic [CSR_DATA_W-1:0] data;
      // Fill the unused upper bits with noise; the block must drop them.
      data       = 16'($urandom);
      data[14:0] = 15'(tgt);
      write_register(CSR_TARGET_STEPS, data);
      write_register(CSR_LEFT_SPEED, left);
      write_register(CSR_RIGHT_SPEED, right);
      data      = 16'($urandom);
      data[8:0] = scale;
      write_register(CSR_BRAKE_SCALE, data);
      write_register(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_INDEX)),
                     16'($urandom));
   endtask

   // Wait until every item is taken and every result is back, then let the
   // pipeline drain before touching the registers.
   task automatic drain_outstanding();
      while (pending_items.size() != 0 || predicted_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_PAUSE) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [8:0] pick_scale();
      case ($urandom_range(0, 5))
         0: return 9'd0;
         1: return 9'd256;
         2: return 9'h1ff;
         3: return BRAKE_SCALE_RESET;
         default: return 9'($urandom_range(0, 511));
      endcase
   endfunction

   // One move: start, walk to the target, at times past it and back, settle
   // on ticks, then a few samples after the finish. A cut move stops early.
   task automatic queue_move(input bit cut);
      logic lvl;
      int   flips;
      lvl   = 1'($urandom_range(0, 1));
      flips = int'(cfg.target_steps) + 2 * $urandom_range(0, 2);
      push_item(OP_START, lvl, 1'($urandom_range(0, 1)));
      for (int i = 0; i < flips; i++) begin
         if (cut && $urandom_range(0, 15) == 0) return;
         repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0)
            push_item(OP_SAMPLE, lvl, $urandom_range(0, 3) == 0);
         lvl = ~lvl;
         push_item(OP_SAMPLE, lvl, $urandom_range(0, 3) == 0);
      end
      repeat ($urandom_range(5, 8)) push_item(OP_SAMPLE, lvl, $urandom_range(0, 5) != 0);
      repeat ($urandom_range(0, 3))
         push_item(OP_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int tgt;
      int phase_start;
      // Drive every input to a known level and hold reset.
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_write              = 1'b0;
      csr_index              = '0;
      csr_data               = '0;
      req_bus.valid          = 1'b0;
      req_bus.operation      = OP_START;
      req_bus.sensor_level   = 1'b0;
      req_bus.period_elapsed = 1'b0;
      rsp_bus.ready          = 1'b0;
      failures         = 0;
      idle_cycles      = 0;
      items_queued     = 0;
      req_taken        = 1'b0;
      burst_left       = 0;
      gap_left         = 0;
      sender_gap_max   = 4;
      rsp_mode         = RX_RANDOM;
      rsp_hold_request = 1'b0;
      hold_left        = 0;
      ready_phase      = 0;
      cfg.target_steps = '0;
      cfg.left_speed   = '0;
      cfg.right_speed  = '0;
      cfg.brake_scale  = BRAKE_SCALE_RESET;
      awaited_lvl      = 1'b0;
      edge_count       = '0;
      reverse_dir      = 1'b0;
      settle_cnt       = '0;
      move_finished    = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: samples while idle after reset, then a start at reset
      // settings with one edge.
      push_item(OP_SAMPLE, 1'b1, 1'b1);
      push_item(OP_SAMPLE, 1'b0, 1'b0);
      push_item(OP_START, 1'b0, 1'b1);
      push_item(OP_SAMPLE, 1'b1, 1'b0);
      drain_outstanding();

      // Directed: brake factor above one overflows inside the brake zone,
      // overshoot reverses, the count returns, five ticks finish the move.
      configure(2, 16'h8000, 16'h7fff, 9'h1ff);
      push_item(OP_START, 1'b1, 1'b1);
      push_item(OP_SAMPLE, 1'b1, 1'b0);
      push_item(OP_SAMPLE, 1'b0, 1'b0);
      push_item(OP_SAMPLE, 1'b1, 1'b1);
      push_item(OP_SAMPLE, 1'b0, 1'b0);
      push_item(OP_SAMPLE, 1'b1, 1'b1);
      repeat (5) push_item(OP_SAMPLE, 1'b1, 1'b1);
      push_item(OP_SAMPLE, 1'b0, 1'b1);
      drain_outstanding();

      // Directed: zero target, full negative speed driven in reverse saturates.
      configure(0, 16'h8000, 16'h8001, 9'd0);
      push_item(OP_START, 1'b1, 1'b0);
      push_item(OP_SAMPLE, 1'b0, 1'b1);
      push_item(OP_SAMPLE, 1'b1, 1'b0);
      repeat (5) push_item(OP_SAMPLE, 1'b1, 1'b1);
      drain_outstanding();

      // Random phases: new settings, sender and receiver behavior each time.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p % 6 == 0)      tgt = $urandom_range(0, 1);
         else if (p % 6 == 5) tgt = $urandom_range(61, 150);
         else                 tgt = $urandom_range(2, 40);
         configure(tgt, pick_speed(), pick_speed(), pick_scale());
         sender_gap_max = (p % 4 == 0) ? 0 : $urandom_range(3, 10);
         rsp_mode       = rx_mode_type'(p % 4);
         // Stall the result side long enough to back up the input.
         if (p == 3) rsp_hold_request = 1'b1;
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
               // Noise: random items, starts included.
               repeat ($urandom_range(1, 8))
                  push_item($urandom_range(0, 3) == 0 ? OP_START : OP_SAMPLE,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               queue_move($urandom_range(0, 5) == 0);
            end
         end
         drain_outstanding();
      end

      if (predicted_cmds.size() != 0) failures++;
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[edge_step_position_controller_unit.f]
hdl/espc_pkg.sv
hdl/esp_req_if.sv
hdl/esp_rsp_if.sv
hdl/espc_front.sv
hdl/espc_queue.sv
hdl/espc_back.sv
hdl/edge_step_position_controller_unit.sv
tb/edge_step_position_controller_unit_tb.sv
